[rtl/ble_pkg.sv]
// Shared types, constants and the microcode program of the bounded list engine.
// Depends on nothing; every other file of the block imports it.
package ble_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int LEN_W      = $clog2(LIST_DEPTH + 1);

  // Fixed field widths of the request and response items.
  localparam int TYPE_W = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 5;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 5;
  localparam int RIDX_W = 4;
  localparam int OLEN_W = 5;

  // Common width for mixing list lengths with the position field.
  localparam int CW = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

  typedef enum logic [TYPE_W-1:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_SEARCH    = 3'd1,
    REQ_INS_POS   = 3'd2,
    REQ_DEL_FIRST = 3'd3,
    REQ_DEL_VAL   = 3'd4,
    REQ_MIDDLE    = 3'd5
  } req_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_INS_FRONT,
    DP_INS_POS,
    DP_CMP,
    DP_COUNT,
    DP_DEL_FIRST,
    DP_DEL_MATCH,
    DP_MID,
    DP_SET_FULL,
    DP_SET_EMPTY,
    DP_SET_NOTFOUND,
    DP_IGNORE
  } dp_op_e;

  typedef enum logic [1:0] {
    C_NONE,
    C_FULL,
    C_EMPTY,
    C_NOMATCH
  } cond_e;

  localparam int PC_W = 5;

  typedef struct packed {
    dp_op_e           op;
    cond_e            cond;
    logic [PC_W-1:0]  target;
    logic             last;
  } uc_word_t;

  // Control handed from the sequencer to the datapath.
  typedef struct packed {
    dp_op_e op;
    logic   emit;
  } ble_ctrl_t;

  // Status handed from the datapath back to the sequencer.
  typedef struct packed {
    logic full;
    logic empty;
    logic no_match;
    logic rsp_held;
  } ble_flags_t;

  localparam logic [PC_W-1:0] PC_INS_FRONT = 5'd0;
  localparam logic [PC_W-1:0] PC_INS_POS   = 5'd2;
  localparam logic [PC_W-1:0] PC_SEARCH    = 5'd4;
  localparam logic [PC_W-1:0] PC_DEL_FIRST = 5'd6;
  localparam logic [PC_W-1:0] PC_DEL_VAL   = 5'd8;
  localparam logic [PC_W-1:0] PC_MIDDLE    = 5'd11;
  localparam logic [PC_W-1:0] PC_FULL      = 5'd13;
  localparam logic [PC_W-1:0] PC_EMPTY     = 5'd14;
  localparam logic [PC_W-1:0] PC_NOTFOUND  = 5'd15;
  localparam logic [PC_W-1:0] PC_IGNORE    = 5'd16;

  function automatic uc_word_t uw(input dp_op_e op, input cond_e cond,
                                  input logic [PC_W-1:0] target, input logic last);
    uc_word_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.last   = last;
    return w;
  endfunction

  function automatic logic [PC_W-1:0] uc_entry(input logic [TYPE_W-1:0] req);
    logic [PC_W-1:0] pc;
    case (req)
      REQ_INS_FRONT: pc = PC_INS_FRONT;
      REQ_SEARCH:    pc = PC_SEARCH;
      REQ_INS_POS:   pc = PC_INS_POS;
      REQ_DEL_FIRST: pc = PC_DEL_FIRST;
      REQ_DEL_VAL:   pc = PC_DEL_VAL;
      REQ_MIDDLE:    pc = PC_MIDDLE;
      default:       pc = PC_IGNORE;
    endcase
    return pc;
  endfunction

  // The program. Each request has a short routine; the full and empty error exits are shared.
  function automatic uc_word_t uc_rom(input logic [PC_W-1:0] pc);
    uc_word_t w;
    case (pc)
      PC_INS_FRONT:         w = uw(DP_NOP,          C_FULL,    PC_FULL,     1'b0);
      PC_INS_FRONT + 5'd1:  w = uw(DP_INS_FRONT,    C_NONE,    PC_IGNORE,   1'b1);
      PC_INS_POS:           w = uw(DP_NOP,          C_FULL,    PC_FULL,     1'b0);
      PC_INS_POS + 5'd1:    w = uw(DP_INS_POS,      C_NONE,    PC_IGNORE,   1'b1);
      PC_SEARCH:            w = uw(DP_CMP,          C_NONE,    PC_IGNORE,   1'b0);
      PC_SEARCH + 5'd1:     w = uw(DP_COUNT,        C_NONE,    PC_IGNORE,   1'b1);
      PC_DEL_FIRST:         w = uw(DP_NOP,          C_EMPTY,   PC_EMPTY,    1'b0);
      PC_DEL_FIRST + 5'd1:  w = uw(DP_DEL_FIRST,    C_NONE,    PC_IGNORE,   1'b1);
      PC_DEL_VAL:           w = uw(DP_CMP,          C_EMPTY,   PC_EMPTY,    1'b0);
      PC_DEL_VAL + 5'd1:    w = uw(DP_NOP,          C_NOMATCH, PC_NOTFOUND, 1'b0);
      PC_DEL_VAL + 5'd2:    w = uw(DP_DEL_MATCH,    C_NONE,    PC_IGNORE,   1'b1);
      PC_MIDDLE:            w = uw(DP_NOP,          C_EMPTY,   PC_EMPTY,    1'b0);
      PC_MIDDLE + 5'd1:     w = uw(DP_MID,          C_NONE,    PC_IGNORE,   1'b1);
      PC_FULL:              w = uw(DP_SET_FULL,     C_NONE,    PC_IGNORE,   1'b1);
      PC_EMPTY:             w = uw(DP_SET_EMPTY,    C_NONE,    PC_IGNORE,   1'b1);
      PC_NOTFOUND:          w = uw(DP_SET_NOTFOUND, C_NONE,    PC_IGNORE,   1'b1);
      default:              w = uw(DP_IGNORE,       C_NONE,    PC_IGNORE,   1'b1);
    endcase
    return w;
  endfunction

  function automatic logic [RIDX_W-1:0] to_ridx(input logic [IDX_W-1:0] idx);
    logic [CW-1:0] w;
    w = CW'(idx);
    return w[RIDX_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] to_cnt(input logic [LEN_W-1:0] n);
    logic [CW-1:0] w;
    w = CW'(n);
    return w[CNT_W-1:0];
  endfunction

endpackage

[rtl/ble_req_if.sv]
// Request channel of the bounded list engine: valid/ready plus the request item.
// Depends on ble_pkg for field widths.
interface ble_req_if;
  import ble_pkg::*;

  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  logic [VAL_W-1:0]  value;
  logic [POS_W-1:0]  position;

  modport source (output valid, req_type, value, position, input ready);
  modport sink   (input valid, req_type, value, position, output ready);
endinterface

[rtl/ble_rsp_if.sv]
// Response channel of the bounded list engine: valid/ready plus the result item.
// Depends on ble_pkg for field widths.
interface ble_rsp_if;
  import ble_pkg::*;

  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [CNT_W-1:0]  match_count;
  logic [VAL_W-1:0]  result_value;
  logic [RIDX_W-1:0] result_index;
  logic [OLEN_W-1:0] list_length;

  modport source (output valid, status, match_count, result_value, result_index,
                  list_length, input ready);
  modport sink   (input valid, status, match_count, result_value, result_index,
                  list_length, output ready);
endinterface

[rtl/ble_seq.sv]
// Microcode sequencer: step counter, program ROM lookup and conditional jumps.
// Depends on ble_pkg for the program and the control/flag structs.
module ble_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ble_pkg::TYPE_W-1:0]    req_type_i,
  input  ble_pkg::ble_flags_t           flags_i,
  output logic                          ready_o,
  output ble_pkg::ble_ctrl_t            ctrl_o
);
  import ble_pkg::*;

  logic            busy_q, busy_d;
  logic [PC_W-1:0] pc_q, pc_d;
  uc_word_t        word;
  logic            taken;
  logic            stall;
  logic            exec;

  always_comb begin
    word = uc_rom(pc_q);
    case (word.cond)
      C_NONE:    taken = 1'b0;
      C_FULL:    taken = flags_i.full;
      C_EMPTY:   taken = flags_i.empty;
      C_NOMATCH: taken = flags_i.no_match;
      default:   taken = 1'b0;
    endcase
    // The final step writes the output register, so it waits for a free slot.
    stall = word.last && flags_i.rsp_held;
    exec  = busy_q && !stall;

    ctrl_o.op   = exec ? word.op : DP_NOP;
    ctrl_o.emit = exec && word.last;
    ready_o     = !busy_q;

    busy_d = busy_q;
    pc_d   = pc_q;
    if (start_i) begin
      busy_d = 1'b1;
      pc_d   = uc_entry(req_type_i);
    end else if (exec) begin
      if (word.last) begin
        busy_d = 1'b0;
      end else if (taken) begin
        pc_d = word.target;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

endmodule

[rtl/ble_dp.sv]
// Datapath: the entry chain with its shift and compare cells, length and
// output register. Depends on ble_pkg for the operation codes and structs.
module ble_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic [ble_pkg::VAL_W-1:0]     value_i,
  input  logic [ble_pkg::POS_W-1:0]     position_i,
  input  ble_pkg::ble_ctrl_t            ctrl_i,
  output ble_pkg::ble_flags_t           flags_o,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic [ble_pkg::ST_W-1:0]      status_o,
  output logic [ble_pkg::CNT_W-1:0]     match_count_o,
  output logic [ble_pkg::VAL_W-1:0]     result_value_o,
  output logic [ble_pkg::RIDX_W-1:0]    result_index_o,
  output logic [ble_pkg::OLEN_W-1:0]    list_length_o
);
  import ble_pkg::*;

  logic [VAL_W-1:0]      ent_q [LIST_DEPTH];
  logic [VAL_W-1:0]      ent_d [LIST_DEPTH];
  logic [LEN_W-1:0]      len_q, len_d;
  logic [VAL_W-1:0]      val_q;
  logic [POS_W-1:0]      pos_q;
  logic [LIST_DEPTH-1:0] match_q, match_d;

  logic                  rsp_valid_q, rsp_valid_d;
  logic [ST_W-1:0]       status_q, status_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [VAL_W-1:0]      rval_q, rval_d;
  logic [RIDX_W-1:0]     ridx_q, ridx_d;
  logic [OLEN_W-1:0]     olen_q, olen_d;

  logic [CW-1:0]         len_c, pos_c, at_c;
  logic [IDX_W-1:0]      ins_at, del_at, first_idx, mid_idx;
  logic [LEN_W-1:0]      hits;
  logic                  do_ins, do_del;

  always_comb begin
    // Clamp the insert position to 1..length+1 and make it 0-based.
    len_c = CW'(len_q);
    pos_c = CW'(pos_q);
    if (pos_c == '0) begin
      pos_c = CW'(1);
    end
    if (pos_c > len_c + CW'(1)) begin
      pos_c = len_c + CW'(1);
    end
    at_c = pos_c - CW'(1);

    first_idx = '0;
    for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        first_idx = IDX_W'(i);
      end
    end

    hits = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      hits = hits + LEN_W'(match_q[i]);
    end

    for (int i = 0; i < LIST_DEPTH; i++) begin
      match_d[i] = (ent_q[i] == val_q) && (LEN_W'(i) < len_q);
    end

    mid_idx = IDX_W'(len_q >> 1);

    ins_at = (ctrl_i.op == DP_INS_POS) ? at_c[IDX_W-1:0] : '0;
    del_at = (ctrl_i.op == DP_DEL_MATCH) ? first_idx : '0;
    do_ins = (ctrl_i.op == DP_INS_FRONT) || (ctrl_i.op == DP_INS_POS);
    do_del = (ctrl_i.op == DP_DEL_FIRST) || (ctrl_i.op == DP_DEL_MATCH);

    // Each cell takes its left or right neighbor, the new value, or holds.
    for (int i = 0; i < LIST_DEPTH; i++) begin
      ent_d[i] = ent_q[i];
      if (do_ins) begin
        if (IDX_W'(i) == ins_at) begin
          ent_d[i] = val_q;
        end else if (i > 0 && IDX_W'(i) > ins_at && LEN_W'(i) <= len_q) begin
          ent_d[i] = ent_q[(i > 0) ? i - 1 : 0];
        end
      end else if (do_del) begin
        if (i < LIST_DEPTH - 1 && IDX_W'(i) >= del_at) begin
          ent_d[i] = ent_q[(i < LIST_DEPTH - 1) ? i + 1 : i];
        end
      end
    end

    len_d = len_q;
    if (do_ins) begin
      len_d = len_q + 1'b1;
    end else if (do_del) begin
      len_d = len_q - 1'b1;
    end

    status_d = ST_OK;
    count_d  = '0;
    rval_d   = '0;
    ridx_d   = '0;
    case (ctrl_i.op)
      DP_INS_FRONT, DP_INS_POS: begin
        rval_d = val_q;
        ridx_d = to_ridx(ins_at);
      end
      DP_COUNT: begin
        count_d  = to_cnt(hits);
        status_d = (hits == '0) ? ST_NOTFOUND : ST_OK;
      end
      DP_DEL_FIRST: begin
        rval_d = ent_q[0];
      end
      DP_DEL_MATCH: begin
        rval_d = val_q;
        ridx_d = to_ridx(first_idx);
      end
      DP_MID: begin
        rval_d = ent_q[mid_idx];
        ridx_d = to_ridx(mid_idx);
      end
      DP_SET_FULL:     status_d = ST_FULL;
      DP_SET_EMPTY:    status_d = ST_EMPTY;
      DP_SET_NOTFOUND: status_d = ST_NOTFOUND;
      default:         status_d = ST_OK;
    endcase
    olen_d = to_cnt(len_d);

    rsp_valid_d = rsp_valid_q;
    if (ctrl_i.emit) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end

    flags_o.full     = (len_q == LEN_W'(LIST_DEPTH));
    flags_o.empty    = (len_q == '0);
    flags_o.no_match = !(|match_q);
    flags_o.rsp_held = rsp_valid_q && !rsp_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    if (load_i) begin
      val_q <= value_i;
      pos_q <= position_i;
    end
    if (ctrl_i.op == DP_CMP) begin
      match_q <= match_d;
    end
    if (ctrl_i.emit) begin
      status_q <= status_d;
      count_q  <= count_d;
      rval_q   <= rval_d;
      ridx_q   <= ridx_d;
      olen_q   <= olen_d;
    end
  end

  assign rsp_valid_o    = rsp_valid_q;
  assign status_o       = status_q;
  assign match_count_o  = count_q;
  assign result_value_o = rval_q;
  assign result_index_o = ridx_q;
  assign list_length_o  = olen_q;

endmodule

[rtl/bounded_list_engine.sv]
// Bounded list engine: an ordered list of signed 32-bit values with insert,
// delete, search and middle requests. Uses ble_pkg, ble_req_if, ble_rsp_if,
// ble_seq and ble_dp.
//
// Usage:
//   req_i carries one request item (req_type, value, position); rsp_o returns
//   exactly one result item per request (status, match_count, result_value,
//   result_index, list_length), in request order.
//   A small microcode program runs each request as a few steps over the
//   entry register chain: inserts check for a full list and then insert,
//   delete first and middle check for an empty list first, search compares
//   and then counts, delete by value compares, checks for no match and
//   then deletes, leaving early on an empty list, and unused request codes
//   are only answered. The result is in the output register the cycle after
//   the last step. One request is in flight at a time; req_i.ready rises
//   again as soon as the last step has run, and the next item may enter
//   while the previous result still waits on rsp_o.
//   If the receiver stalls, the last step of the following item waits until
//   the output register is free; nothing is dropped.
//   Reset empties the list, clears rsp_o.valid and raises req_i.ready; entry
//   contents are not cleared, since entries beyond the length are never read.
module bounded_list_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  ble_req_if.sink    req_i,
  ble_rsp_if.source  rsp_o
);
  import ble_pkg::*;

  ble_ctrl_t  ctrl;
  ble_flags_t flags;
  logic       start;
  logic       ready;

  assign req_i.ready = ready;
  assign start       = req_i.valid && ready;

  ble_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_type_i (req_i.req_type),
    .flags_i    (flags),
    .ready_o    (ready),
    .ctrl_o     (ctrl)
  );

  ble_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (start),
    .value_i        (req_i.value),
    .position_i     (req_i.position),
    .ctrl_i         (ctrl),
    .flags_o        (flags),
    .rsp_valid_o    (rsp_o.valid),
    .rsp_ready_i    (rsp_o.ready),
    .status_o       (rsp_o.status),
    .match_count_o  (rsp_o.match_count),
    .result_value_o (rsp_o.result_value),
    .result_index_o (rsp_o.result_index),
    .list_length_o  (rsp_o.list_length)
  );

endmodule
